### design/qrs_pkg.sv
package qrs_pkg;

  // Root format: signed, fixed 32-bit word
  localparam int ROOT_W = 32;
  localparam logic [ROOT_W-1:0] ROOT_MAX = {1'b0, {(ROOT_W-1){1'b1}}};
  localparam logic [ROOT_W-1:0] ROOT_MIN = {1'b1, {(ROOT_W-1){1'b0}}};

  // Queue between the classifier and the solver pipeline
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int LVL_W       = $clog2(QUEUE_DEPTH + 1);

  // Result class codes
  typedef enum logic [2:0] {
    CLS_TWO    = 3'd0,
    CLS_DOUBLE = 3'd1,
    CLS_NONE   = 3'd2,
    CLS_LINEAR = 3'd3,
    CLS_DEGEN  = 3'd4
  } qrs_class_t;

  // Control that rides along with each item
  typedef struct packed {
    qrs_class_t cls;
    logic       dv_neg;   // divisor was negative
  } qrs_ctl_t;

  localparam int CTL_W = $bits(qrs_ctl_t);

endpackage

### design/qrs_front.sv
module qrs_front #(
  parameter int CW = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [CW-1:0]          coef_a,
  input  logic signed [CW-1:0]          coef_b,
  input  logic signed [CW-1:0]          coef_c,
  input  logic [qrs_pkg::LVL_W-1:0]     fifo_level,
  output logic                          push,
  output qrs_pkg::qrs_ctl_t             job_ctl,
  output logic [2*CW:0]                 job_disc,
  output logic signed [CW:0]            job_base,
  output logic [CW:0]                   job_dmag
);
  import qrs_pkg::*;

  localparam int DSW = 2*CW + 2;
  localparam int LW  = LVL_W + 1;

  logic                 accept;
  logic                 v0_r, v1_r;
  logic signed [CW-1:0] a0_r, b0_r, c0_r;
  logic signed [CW-1:0] a1_r, b1_r, c1_r;
  logic signed [2*CW-1:0] ac1_r, bb1_r;
  logic signed [DSW-1:0]  disc_s;
  logic signed [CW:0]     b_ext, c_ext, dv;
  logic                   a_zero, b_zero;

  // Hold off when queued plus in-flight items could fill the queue
  assign busy   = (LW'(fifo_level) + LW'(v0_r) + LW'(v1_r)) >= LW'(QUEUE_DEPTH);
  assign accept = start & ~busy;

  // Valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= accept;
      v1_r <= v0_r;
    end
  end

  // Capture coefficients, then form products
  always_ff @(posedge clk) begin
    if (accept) begin
      a0_r <= coef_a;
      b0_r <= coef_b;
      c0_r <= coef_c;
    end
    if (v0_r) begin
      a1_r  <= a0_r;
      b1_r  <= b0_r;
      c1_r  <= c0_r;
      ac1_r <= a0_r * c0_r;
      bb1_r <= b0_r * b0_r;
    end
  end

  // Discriminant and classification
  assign disc_s = DSW'(bb1_r) - (DSW'(ac1_r) <<< 2);
  assign a_zero = (a1_r == '0);
  assign b_zero = (b1_r == '0);
  assign b_ext  = (CW+1)'(b1_r);
  assign c_ext  = (CW+1)'(c1_r);

  always_comb begin
    job_disc = '0;
    if (!a_zero) begin
      dv       = {a1_r, 1'b0};
      job_base = -b_ext;
      if (disc_s > 0) begin
        job_ctl.cls = CLS_TWO;
        job_disc    = disc_s[2*CW:0];
      end else if (disc_s == 0) begin
        job_ctl.cls = CLS_DOUBLE;
      end else begin
        job_ctl.cls = CLS_NONE;
      end
    end else begin
      dv       = b_ext;
      job_base = -c_ext;
      job_ctl.cls = b_zero ? CLS_DEGEN : CLS_LINEAR;
    end
    job_ctl.dv_neg = dv[CW];
    job_dmag       = dv[CW] ? (~dv + 1'b1) : dv;
  end

  assign push = v1_r;

endmodule

### design/qrs_queue.sv
module qrs_queue #(
  parameter int W = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  logic [W-1:0]              din,
  output logic                      dout_valid,
  output logic [W-1:0]              dout,
  output logic [qrs_pkg::LVL_W-1:0] level
);
  import qrs_pkg::*;

  logic [W-1:0]        mem_r [0:QUEUE_DEPTH-1];
  logic [QUEUE_AW-1:0] wr_r, rd_r;
  logic [LVL_W-1:0]    cnt_r, cnt_nxt;
  logic                pop;

  // The solver pipeline never stalls, so pop whenever something is held
  assign pop        = (cnt_r != '0);
  assign dout_valid = pop;
  assign dout       = mem_r[rd_r];
  assign level      = cnt_r;

  assign cnt_nxt = cnt_r + LVL_W'(push) - LVL_W'(pop);

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + QUEUE_AW'(1);
      if (pop)  rd_r <= rd_r + QUEUE_AW'(1);
      cnt_r <= cnt_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= din;
  end

endmodule

### design/qrs_sqrt.sv
module qrs_sqrt #(
  parameter int DW = 33,
  parameter int R  = 16,
  parameter int PW = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [DW-1:0]                disc,
  input  logic [PW-1:0]                pay,
  output logic                         out_valid,
  output logic [(DW+2*R+1)/2-1:0]      root,
  output logic                         exact,
  output logic [PW-1:0]                pay_o
);

  localparam int TW    = DW + 2*R;
  localparam int SW    = (TW + 1) / 2;
  localparam int RAD_W = 2*SW;
  localparam int RW    = SW + 2;

  logic [RAD_W-1:0] rad_r  [0:SW-1];
  logic [RW-1:0]    rem_r  [0:SW-1];
  logic [SW-1:0]    root_r [0:SW-1];
  logic             v_r    [0:SW-1];
  logic [PW-1:0]    pay_r  [0:SW-1];

  // One result bit per stage, most significant first
  for (genvar i = 0; i < SW; i++) begin : g_stage
    logic [RAD_W-1:0] rad_in;
    logic [RW-1:0]    rem_in, rem_sh, trial;
    logic [SW-1:0]    root_in;
    logic             v_in, fit;
    logic [PW-1:0]    pay_in;

    if (i == 0) begin : g_first
      assign rad_in  = RAD_W'(disc) << (2*R);
      assign rem_in  = '0;
      assign root_in = '0;
      assign v_in    = in_valid;
      assign pay_in  = pay;
    end else begin : g_next
      assign rad_in  = rad_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign v_in    = v_r[i-1];
      assign pay_in  = pay_r[i-1];
    end

    assign rem_sh = {rem_in[SW-1:0], rad_in[RAD_W-1 -: 2]};
    assign trial  = {root_in, 2'b01};
    assign fit    = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) v_r[i] <= 1'b0;
      else        v_r[i] <= v_in;
    end

    always_ff @(posedge clk) begin
      rad_r[i]  <= rad_in << 2;
      rem_r[i]  <= fit ? (rem_sh - trial) : rem_sh;
      root_r[i] <= {root_in[SW-2:0], fit};
      pay_r[i]  <= pay_in;
    end
  end

  assign out_valid = v_r[SW-1];
  assign root      = root_r[SW-1];
  assign exact     = (rem_r[SW-1] == '0) && (rad_r[SW-1] == '0);
  assign pay_o     = pay_r[SW-1];

endmodule

### design/qrs_div.sv
module qrs_div #(
  parameter int NW = 34,
  parameter int VW = 17,
  parameter int PW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [VW-1:0] den,
  input  logic [PW-1:0] pay,
  output logic          out_valid,
  output logic [NW-1:0] quot,
  output logic [PW-1:0] pay_o
);

  logic [NW-1:0] num_r [0:NW-1];
  logic [VW-1:0] rem_r [0:NW-1];
  logic [VW-1:0] den_r [0:NW-1];
  logic          v_r   [0:NW-1];
  logic [PW-1:0] pay_r [0:NW-1];

  // Restoring division, one quotient bit per stage; the dividend
  // register fills with quotient bits from the bottom
  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [NW-1:0] num_in;
    logic [VW-1:0] rem_in, den_in;
    logic [VW:0]   rem_sh, rem_sub;
    logic          v_in, fit;
    logic [PW-1:0] pay_in;

    if (i == 0) begin : g_first
      assign num_in = num;
      assign rem_in = '0;
      assign den_in = den;
      assign v_in   = in_valid;
      assign pay_in = pay;
    end else begin : g_next
      assign num_in = num_r[i-1];
      assign rem_in = rem_r[i-1];
      assign den_in = den_r[i-1];
      assign v_in   = v_r[i-1];
      assign pay_in = pay_r[i-1];
    end

    assign rem_sh  = {rem_in, num_in[NW-1]};
    assign rem_sub = rem_sh - {1'b0, den_in};
    assign fit     = (rem_sh >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (!rst_n) v_r[i] <= 1'b0;
      else        v_r[i] <= v_in;
    end

    always_ff @(posedge clk) begin
      num_r[i] <= {num_in[NW-2:0], fit};
      rem_r[i] <= fit ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
      den_r[i] <= den_in;
      pay_r[i] <= pay_in;
    end
  end

  assign out_valid = v_r[NW-1];
  assign quot      = num_r[NW-1];
  assign pay_o     = pay_r[NW-1];

endmodule

### design/quadratic_root_solver.sv
// Quadratic root solver: real roots of a*x^2 + b*x + c = 0.
// Input channel: drive in_coef_a/b/c (signed, same fixed-point scale) and
// raise start; the item is taken at a clock edge where start is high and
// busy is low. Result channel: out_strobe is high for one cycle with the
// class code, both roots (signed, ROOT_FRAC_BITS fraction bits, truncated
// toward zero, saturated to 32 bits) and the saturation flag.
// A classifier computes b^2-4ac and the case, then hands the item through a
// four-entry queue to a solver pipeline: a square-root pipeline with one
// bit per stage, then two divider pipelines (one per root) with one
// quotient bit per stage. While busy is low one item per cycle is
// accepted and one result per cycle is produced. From accept to strobe
// an item passes the front registers, the queue, the square-root stages,
// the numerator registers, the divider stages and the result register.
// The receiver cannot stall; busy only guards the queue and stays low in
// steady use. Synchronous reset clears all valid bits; items in flight
// are dropped and no strobe is raised until new items arrive.
module quadratic_root_solver #(
  parameter int COEF_BITS      = 16,
  parameter int ROOT_FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [COEF_BITS-1:0]        in_coef_a,
  input  logic signed [COEF_BITS-1:0]        in_coef_b,
  input  logic signed [COEF_BITS-1:0]        in_coef_c,
  output logic                               out_strobe,
  output logic [2:0]                         out_root_class,
  output logic signed [qrs_pkg::ROOT_W-1:0]  out_root_low,
  output logic signed [qrs_pkg::ROOT_W-1:0]  out_root_high,
  output logic                               out_saturated
);
  import qrs_pkg::*;

  localparam int CW  = COEF_BITS;
  localparam int R   = ROOT_FRAC_BITS;
  localparam int DW  = 2*CW + 1;
  localparam int VW  = CW + 1;
  localparam int TW  = DW + 2*R;
  localparam int SW  = (TW + 1) / 2;
  localparam int KW  = ((CW + R > SW) ? CW + R : SW) + 2;
  localparam int NW  = KW - 1;
  localparam int EW  = (NW >= ROOT_W) ? NW + 1 : ROOT_W + 1;
  localparam int JW  = CTL_W + DW + VW + VW;
  localparam int SPW = CTL_W + VW + VW;
  localparam logic [EW-1:0] POS_LIM = EW'(ROOT_MAX);
  localparam logic [EW-1:0] NEG_LIM = EW'(ROOT_MIN);

  // Front to queue
  logic                  push;
  qrs_ctl_t              f_ctl;
  logic [DW-1:0]         f_disc;
  logic signed [VW-1:0]  f_base;
  logic [VW-1:0]         f_dmag;
  logic [LVL_W-1:0]      q_level;

  // Queue to solver
  logic                  q_valid;
  logic [JW-1:0]         q_dout;
  qrs_ctl_t              q_ctl;
  logic [DW-1:0]         q_disc;
  logic [VW-1:0]         q_base;
  logic [VW-1:0]         q_dmag;

  // Square-root output
  logic                  s_valid, s_exact;
  logic [SW-1:0]         s_root;
  logic [SPW-1:0]        s_pay;
  qrs_ctl_t              s_ctl;
  logic signed [VW-1:0]  s_base;
  logic [VW-1:0]         s_dmag;
  logic signed [KW-1:0]  n0;

  // Numerator stages
  logic                  k_v_r;
  qrs_ctl_t              k_ctl_r;
  logic                  k_exact_r;
  logic [VW-1:0]         k_dmag_r;
  logic signed [KW-1:0]  klo_r, khi_r;
  logic [KW-1:0]         klo_neg, khi_neg;
  logic                  m_v_r;
  qrs_ctl_t              m_ctl_r;
  logic [VW-1:0]         m_dmag_r;
  logic [NW-1:0]         mlo_r, mhi_r;
  logic                  nlo_r, nhi_r;

  // Divider outputs
  logic                  dlo_valid, dhi_valid;
  logic [NW-1:0]         dlo_q, dhi_q;
  logic [CTL_W:0]        dlo_pay;
  logic                  dhi_neg;
  qrs_ctl_t              d_ctl;
  logic                  dlo_neg;
  logic [EW-1:0]         lo_qx, hi_qx;
  logic                  lo_sat, hi_sat;
  logic [ROOT_W-1:0]     lo_val, hi_val;

  // Output registers
  logic                  strobe_r;
  qrs_class_t            cls_r;
  logic [ROOT_W-1:0]     lo_r, hi_r;
  logic                  sat_r;

  qrs_front #(.CW(CW)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .coef_a     (in_coef_a),
    .coef_b     (in_coef_b),
    .coef_c     (in_coef_c),
    .fifo_level (q_level),
    .push       (push),
    .job_ctl    (f_ctl),
    .job_disc   (f_disc),
    .job_base   (f_base),
    .job_dmag   (f_dmag)
  );

  qrs_queue #(.W(JW)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .din        ({f_ctl, f_disc, f_base, f_dmag}),
    .dout_valid (q_valid),
    .dout       (q_dout),
    .level      (q_level)
  );

  assign q_ctl  = qrs_ctl_t'(q_dout[JW-1 -: CTL_W]);
  assign q_disc = q_dout[2*VW +: DW];
  assign q_base = q_dout[VW +: VW];
  assign q_dmag = q_dout[VW-1:0];

  qrs_sqrt #(.DW(DW), .R(R), .PW(SPW)) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (q_valid),
    .disc      (q_disc),
    .pay       ({q_ctl, q_base, q_dmag}),
    .out_valid (s_valid),
    .root      (s_root),
    .exact     (s_exact),
    .pay_o     (s_pay)
  );

  assign s_ctl  = qrs_ctl_t'(s_pay[SPW-1 -: CTL_W]);
  assign s_base = s_pay[VW +: VW];
  assign s_dmag = s_pay[VW-1:0];
  assign n0     = KW'(s_base) <<< R;

  // Numerators: the irrational part lies strictly between k and k+1
  always_ff @(posedge clk) begin
    if (!rst_n) k_v_r <= 1'b0;
    else        k_v_r <= s_valid;
  end

  always_ff @(posedge clk) begin
    k_ctl_r   <= s_ctl;
    k_exact_r <= s_exact;
    k_dmag_r  <= s_dmag;
    klo_r     <= n0 - KW'(s_root) - KW'(!s_exact);
    khi_r     <= n0 + KW'(s_root);
  end

  // Magnitudes and result signs; inexact negatives use ~k for truncation
  assign klo_neg = k_exact_r ? -klo_r : ~klo_r;
  assign khi_neg = k_exact_r ? -khi_r : ~khi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) m_v_r <= 1'b0;
    else        m_v_r <= k_v_r;
  end

  always_ff @(posedge clk) begin
    m_ctl_r  <= k_ctl_r;
    m_dmag_r <= k_dmag_r;
    mlo_r    <= klo_r[KW-1] ? klo_neg[NW-1:0] : klo_r[NW-1:0];
    mhi_r    <= khi_r[KW-1] ? khi_neg[NW-1:0] : khi_r[NW-1:0];
    nlo_r    <= klo_r[KW-1] ^ k_ctl_r.dv_neg;
    nhi_r    <= khi_r[KW-1] ^ k_ctl_r.dv_neg;
  end

  qrs_div #(.NW(NW), .VW(VW), .PW(CTL_W + 1)) u_div_lo (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (m_v_r),
    .num       (mlo_r),
    .den       (m_dmag_r),
    .pay       ({m_ctl_r, nlo_r}),
    .out_valid (dlo_valid),
    .quot      (dlo_q),
    .pay_o     (dlo_pay)
  );

  qrs_div #(.NW(NW), .VW(VW), .PW(1)) u_div_hi (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (m_v_r),
    .num       (mhi_r),
    .den       (m_dmag_r),
    .pay       (nhi_r),
    .out_valid (dhi_valid),
    .quot      (dhi_q),
    .pay_o     (dhi_neg)
  );

  assign d_ctl   = qrs_ctl_t'(dlo_pay[CTL_W:1]);
  assign dlo_neg = dlo_pay[0];
  assign lo_qx   = EW'(dlo_q);
  assign hi_qx   = EW'(dhi_q);

  // Sign and saturation
  always_comb begin
    lo_sat = dlo_neg ? (lo_qx > NEG_LIM) : (lo_qx > POS_LIM);
    hi_sat = dhi_neg ? (hi_qx > NEG_LIM) : (hi_qx > POS_LIM);
    if (lo_sat)       lo_val = dlo_neg ? ROOT_MIN : ROOT_MAX;
    else if (dlo_neg) lo_val = ~lo_qx[ROOT_W-1:0] + ROOT_W'(1);
    else              lo_val = lo_qx[ROOT_W-1:0];
    if (hi_sat)       hi_val = dhi_neg ? ROOT_MIN : ROOT_MAX;
    else if (dhi_neg) hi_val = ~hi_qx[ROOT_W-1:0] + ROOT_W'(1);
    else              hi_val = hi_qx[ROOT_W-1:0];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) strobe_r <= 1'b0;
    else        strobe_r <= dlo_valid & dhi_valid;
  end

  always_ff @(posedge clk) begin
    cls_r <= d_ctl.cls;
    if (d_ctl.cls == CLS_NONE || d_ctl.cls == CLS_DEGEN) begin
      lo_r  <= '0;
      hi_r  <= '0;
      sat_r <= 1'b0;
    end else begin
      lo_r  <= lo_val;
      hi_r  <= hi_val;
      sat_r <= lo_sat | hi_sat;
    end
  end

  assign out_strobe     = strobe_r;
  assign out_root_class = cls_r;
  assign out_root_low   = lo_r;
  assign out_root_high  = hi_r;
  assign out_saturated  = sat_r;

endmodule

### dv/testbench.sv
module testbench;
  import qrs_pkg::*;

  // Expected outcome of one equation
  typedef struct {
    qrs_class_t  cls;
    logic [31:0] lo;
    logic [31:0] hi;
    logic        sat;
  } roots_t;

  // Directed row: coefficients, plus a typed answer where it is obvious
  typedef struct {
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] c;
    bit          typed;
    roots_t      ans;
  } coef_row_t;

  localparam int N_RANDOM = 600;
  localparam int TAIL_CYCLES = 200;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [15:0] in_coef_a;
  logic [15:0] in_coef_b;
  logic [15:0] in_coef_c;
  logic        out_strobe;
  logic [2:0]  out_root_class;
  logic [31:0] out_root_low;
  logic [31:0] out_root_high;
  logic        out_saturated;

  roots_t pending_roots[$];
  int     mismatches = 0;

  quadratic_root_solver uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_coef_a(in_coef_a), .in_coef_b(in_coef_b), .in_coef_c(in_coef_c),
    .out_strobe(out_strobe), .out_root_class(out_root_class),
    .out_root_low(out_root_low), .out_root_high(out_root_high),
    .out_saturated(out_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 400000);
    $display("TEST FAILED");
    $finish;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  // Integer square root (floor) of a 128-bit value below 2**126
  function automatic logic [63:0] isqrt(input logic [127:0] t);
    logic [63:0]  s;
    logic [127:0] cand;
    s = '0;
    for (int bi = 62; bi >= 0; bi--) begin
      cand = {64'd0, s | (64'd1 << bi)};
      if (cand * cand <= t) s = cand[63:0];
    end
    return s;
  endfunction

  // Truncated (n0 +/- sqrt)/d; inexact sqrt means numerator is strictly between k and k+1
  function automatic longint div_root(input longint n0, input bit plus, input longint s,
                                      input bit exact, input longint d);
    longint k;
    longint fl;
    if (exact) begin
      k = plus ? n0 + s : n0 - s;
      if (d < 0) begin
        k = -k;
        d = -d;
      end
      return k / d;
    end
    k = plus ? n0 + s : n0 - s - 1;
    if (d < 0) begin
      k = -k - 1;
      d = -d;
    end
    fl = k / d;
    if ((k % d) != 0 && k < 0) fl--;
    return fl >= 0 ? fl : fl + 1;
  endfunction

  function automatic longint clip32(input longint v, inout logic sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic roots_t solve_roots(input logic [15:0] ar, input logic [15:0] br,
                                         input logic [15:0] cr);
    roots_t       r;
    longint       a, b, c, dsc, n0, lo, hi;
    logic [63:0]  s;
    logic [127:0] t;
    bit           exact;
    a = longint'($signed(ar));
    b = longint'($signed(br));
    c = longint'($signed(cr));
    r.sat = 1'b0;
    lo = 0;
    hi = 0;
    if (a != 0) begin
      dsc = b * b - 4 * a * c;
      n0 = -b * 65536;
      if (dsc > 0) begin
        t = {64'd0, dsc} << 32;
        s = isqrt(t);
        exact = ({64'd0, s} * {64'd0, s}) == t;
        lo = clip32(div_root(n0, 1'b0, longint'(s), exact, 2 * a), r.sat);
        hi = clip32(div_root(n0, 1'b1, longint'(s), exact, 2 * a), r.sat);
        r.cls = CLS_TWO;
      end else if (dsc == 0) begin
        lo = clip32(div_root(n0, 1'b1, 0, 1'b1, 2 * a), r.sat);
        hi = lo;
        r.cls = CLS_DOUBLE;
      end else begin
        r.cls = CLS_NONE;
      end
    end else if (b != 0) begin
      lo = clip32(div_root(-c * 65536, 1'b1, 0, 1'b1, b), r.sat);
      hi = lo;
      r.cls = CLS_LINEAR;
    end else begin
      r.cls = CLS_DEGEN;
    end
    r.lo = lo[31:0];
    r.hi = hi[31:0];
    return r;
  endfunction

  // Present one item and hold it until taken; the answer is queued at acceptance
  task automatic send_item(input logic [15:0] a, input logic [15:0] b, input logic [15:0] c,
                           input bit typed, input roots_t ans);
    start <= 1'b1;
    in_coef_a <= a;
    in_coef_b <= b;
    in_coef_c <= c;
    do @(posedge clk); while (busy);
    pending_roots.push_back(typed ? ans : solve_roots(a, b, c));
  endtask

  // Check every strobed result against the oldest answer
  always @(posedge clk) begin
    roots_t w;
    if (rst_n && out_strobe) begin
      if (pending_roots.size() == 0) begin
        report("unexpected result", {29'd0, out_root_class}, 32'd0);
      end else begin
        w = pending_roots.pop_front();
        if (out_root_class !== w.cls) report("class", {29'd0, out_root_class}, {29'd0, w.cls});
        if (out_root_low !== w.lo) report("root_low", out_root_low, w.lo);
        if (out_root_high !== w.hi) report("root_high", out_root_high, w.hi);
        if (out_saturated !== w.sat) report("saturated", {31'd0, out_saturated}, {31'd0, w.sat});
      end
    end
  end

  coef_row_t rows[] = '{
    '{16'h0000, 16'h0000, 16'h0000, 1, '{CLS_DEGEN, 32'h0, 32'h0, 1'b0}},
    '{16'h0000, 16'h0000, 16'h8000, 1, '{CLS_DEGEN, 32'h0, 32'h0, 1'b0}},
    '{16'h0000, 16'h0100, 16'h0100, 1, '{CLS_LINEAR, 32'hffff0000, 32'hffff0000, 1'b0}},
    '{16'h0000, 16'h0001, 16'h8000, 1, '{CLS_LINEAR, 32'h7fffffff, 32'h7fffffff, 1'b1}},
    '{16'h0000, 16'hffff, 16'h8000, 1, '{CLS_LINEAR, 32'h80000000, 32'h80000000, 1'b0}},
    '{16'h0000, 16'h0001, 16'h7fff, 1, '{CLS_LINEAR, 32'h80010000, 32'h80010000, 1'b0}},
    '{16'h0100, 16'h0000, 16'h0100, 1, '{CLS_NONE, 32'h0, 32'h0, 1'b0}},
    '{16'h0100, 16'h0200, 16'h0100, 1, '{CLS_DOUBLE, 32'hffff0000, 32'hffff0000, 1'b0}},
    '{16'h0100, 16'h0000, 16'hff00, 1, '{CLS_TWO, 32'hffff0000, 32'h00010000, 1'b0}},
    '{16'h0001, 16'h7fff, 16'h0000, 0, '{CLS_TWO, 32'h0, 32'h0, 1'b0}},
    '{16'h0001, 16'h8000, 16'h8000, 0, '{CLS_TWO, 32'h0, 32'h0, 1'b0}},
    '{16'h8000, 16'h8000, 16'h8000, 0, '{CLS_TWO, 32'h0, 32'h0, 1'b0}},
    '{16'h7fff, 16'h7fff, 16'h7fff, 0, '{CLS_TWO, 32'h0, 32'h0, 1'b0}},
    '{16'h8000, 16'h7fff, 16'h7fff, 0, '{CLS_TWO, 32'h0, 32'h0, 1'b0}},
    '{16'hffff, 16'h0000, 16'h7fff, 0, '{CLS_TWO, 32'h0, 32'h0, 1'b0}},
    '{16'h0001, 16'h0003, 16'h0001, 0, '{CLS_TWO, 32'h0, 32'h0, 1'b0}},
    '{16'hffff, 16'h0002, 16'hffff, 0, '{CLS_TWO, 32'h0, 32'h0, 1'b0}},
    '{16'h0300, 16'h0100, 16'hfe00, 0, '{CLS_TWO, 32'h0, 32'h0, 1'b0}},
    '{16'h0100, 16'h0080, 16'h0000, 0, '{CLS_TWO, 32'h0, 32'h0, 1'b0}}
  };

  // Stimulus: reset, directed rows, then random equations
  initial begin
    roots_t      none;
    logic [15:0] a, b, c;
    int          pick;
    bit          quiet;
    none = '{CLS_TWO, 32'h0, 32'h0, 1'b0};
    rst_n = 1'b0;
    start = 1'b0;
    in_coef_a = '0;
    in_coef_b = '0;
    in_coef_c = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if ($urandom_range(99) < 25) begin
        start <= 1'b0;
        repeat ($urandom_range(4, 1)) @(posedge clk);
      end
      send_item(rows[i].a, rows[i].b, rows[i].c, rows[i].typed, rows[i].ans);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      quiet = (n >= 150 && n < 300);
      // hold off once until the pipeline has drained
      if (n == 320) begin
        start <= 1'b0;
        while (pending_roots.size() != 0) @(posedge clk);
      end
      if (!quiet && $urandom_range(99) < 25) begin
        start <= 1'b0;
        repeat ($urandom_range(6, 1)) @(posedge clk);
      end
      a = $urandom;
      b = $urandom;
      c = $urandom;
      pick = $urandom_range(9);
      case (pick)
        0: a = '0;
        1: begin
          a = '0;
          b = '0;
        end
        2: begin
          a = $signed(8'($urandom));
          b = $signed(8'($urandom));
          c = $signed(8'($urandom));
        end
        3: begin
          // perfect square: a*(x-r)^2 gives a double root
          a = $signed(4'($urandom)) * 16'sd2;
          if (a == 0) a = 16'd2;
          b = -16'sd2 * $signed(a) * $signed(4'($urandom));
          c = 16'((32'($signed(b)) * 32'($signed(b))) / (32'sd4 * 32'($signed(a))));
        end
        4: c = {1'b1, c[14:0]};
        default: ;
      endcase
      send_item(a, b, c, 1'b0, none);
    end
    start <= 1'b0;

    while (pending_roots.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sim.f
design/qrs_pkg.sv
design/qrs_front.sv
design/qrs_queue.sv
design/qrs_sqrt.sv
design/qrs_div.sv
design/quadratic_root_solver.sv
dv/testbench.sv
